// ----- hw/rtl/hgs_pkg.sv -----
// Shared constants, codes and helpers for the hexapod gait sequencer.
package hgs_pkg;

  localparam int LEGS_DEF       = 6;
  localparam int STEPS_DEF      = 10;
  localparam int COORD_BITS_DEF = 16;

  localparam int Q_FRAC   = 16;
  localparam int T_W      = 16;
  localparam int STRIDE_W = 10;
  localparam int MODE_W   = 2;
  localparam int REQ_W    = 2;
  localparam int LEG_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int STZ_W    = 27;

  localparam logic [STRIDE_W-1:0] STRIDE_Z_RST = 10'd30;

  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REPORT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_Z = 2'd2;

  localparam logic [MODE_W-1:0] GAIT_IDLE = 2'd0;

  // Tripod start order: legs with index mod 4 of 0 or 3 first, then the rest
  function automatic int tripod_leg(int legs, int pos);
    int n;
    int res;
    n = 0;
    res = 0;
    for (int i = 0; i < 8; i++) begin
      if (i < legs && ((i % 4) == 0 || (i % 4) == 3)) begin
        if (n == pos) res = i;
        n = n + 1;
      end
    end
    for (int i = 0; i < 8; i++) begin
      if (i < legs && !((i % 4) == 0 || (i % 4) == 3)) begin
        if (n == pos) res = i;
        n = n + 1;
      end
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/hexapod_gait_sequencer.sv -----
// Gait sequencer top level: request decode, leg stores and target sequencer.
//
//   channel  dir  payload
//   s_*      in   tuser: req_type; tdata: leg, pos_x, pos_y, pos_z, any_leg_moving
//   m_*      out  tuser: swinging; tlast: last; tdata: target_leg, target_x/y/z
//   cfg_*    in   write of gait_mode, stride_x, stride_z
//
// Load, report and ignored ticks complete in their accept cycle. An active tick
// then emits LEGS targets; every interpolation runs through one three-stage
// interpolation unit, and a pass is issued only when the previous one is done:
// a swing leg takes 3 axes x 3 passes, a stance leg 3 axes x 1 pass, and output
// stalls add to this. s_tready is low throughout.
// Reset is synchronous; each target waits in its output register for m_tready.
module hexapod_gait_sequencer #(
  parameter int LEGS       = hgs_pkg::LEGS_DEF,
  parameter int STEPS      = hgs_pkg::STEPS_DEF,
  parameter int COORD_BITS = hgs_pkg::COORD_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // leg, pos_x, pos_y, pos_z, any_leg_moving
  input  logic [((3*COORD_BITS+hgs_pkg::LEG_W+8)/8)*8-1:0] s_tdata,
  // req_type
  input  logic [hgs_pkg::REQ_W-1:0]                 s_tuser,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // target_leg, target_x, target_y, target_z
  output logic [((3*COORD_BITS+hgs_pkg::LEG_W+7)/8)*8-1:0] m_tdata,
  // swinging
  output logic                                      m_tuser,
  output logic                                      m_tlast,
  input  logic                                      cfg_we,
  input  logic [hgs_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic [hgs_pkg::STRIDE_W-1:0]              cfg_data
);
  import hgs_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int LW  = $clog2(LEGS);
  localparam int KW  = $clog2(STEPS);
  localparam int MW  = C + 2;
  localparam int W   = MW + Q_FRAC;
  localparam int MDW = ((3*C + LEG_W + 7) / 8) * 8;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  localparam logic [1:0] OP_L1  = 2'd0;
  localparam logic [1:0] OP_L2  = 2'd1;
  localparam logic [1:0] OP_FIN = 2'd2;

  localparam logic [1:0] G_ONE = 2'd0;
  localparam logic [1:0] G_TRI = 2'd1;
  localparam logic [1:0] G_TWO = 2'd2;

  localparam logic signed [W:0]  RND_POS = (W+1)'(1 <<< (Q_FRAC - 1));
  localparam logic signed [W:0]  RND_NEG = (W+1)'((1 <<< (Q_FRAC - 1)) - 1);
  localparam logic signed [MW:0] SAT_HI  = (MW+1)'((1 <<< (C - 1)) - 1);
  localparam logic signed [MW:0] SAT_LO  = (MW+1)'(-(1 <<< (C - 1)));

  typedef enum logic [2:0] {
    ST_IDLE, ST_AXIS, ST_ISSUE, ST_WAIT, ST_CONV, ST_SEND
  } state_t;

  // configuration
  logic [MODE_W-1:0]          gait_mode;
  logic signed [STRIDE_W-1:0] stride_x;
  logic signed [STRIDE_W-1:0] stride_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      gait_mode <= GAIT_IDLE;
      stride_x  <= '0;
      stride_z  <= STRIDE_Z_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:     gait_mode <= cfg_data[MODE_W-1:0];
        CFG_STRIDE_X: stride_x  <= cfg_data;
        CFG_STRIDE_Z: stride_z  <= cfg_data;
        default: ;
      endcase
    end
  end

  // request fields
  logic [LEG_W-1:0]    in_leg;
  logic signed [C-1:0] in_x;
  logic signed [C-1:0] in_y;
  logic signed [C-1:0] in_z;
  logic                in_moving;

  assign in_leg    = s_tdata[LEG_W-1:0];
  assign in_x      = s_tdata[LEG_W +: C];
  assign in_y      = s_tdata[LEG_W+C +: C];
  assign in_z      = s_tdata[LEG_W+2*C +: C];
  assign in_moving = s_tdata[LEG_W+3*C];

  state_t              state;
  logic [LW-1:0]       slot;
  logic [1:0]          axis;
  logic [1:0]          op;
  logic [1:0]          g;
  logic [T_W-1:0]      t;
  logic signed [STZ_W-1:0] stz;
  logic signed [W-1:0] l1;
  logic signed [W-1:0] l2;
  logic signed [W-1:0] r;
  logic signed [C-1:0] out_x;
  logic signed [C-1:0] out_y;
  logic signed [C-1:0] out_z;
  logic [LW-1:0]       out_leg;
  logic                out_sw;
  logic                out_last;
  logic [LW-1:0]       order [3][LEGS];
  logic [KW-1:0]       phase [3];
  logic                primed;

  // leg stores
  logic signed [C-1:0] neu_x [LEGS];
  logic signed [C-1:0] neu_y [LEGS];
  logic signed [C-1:0] neu_z [LEGS];
  logic signed [C-1:0] meas_x [LEGS];
  logic signed [C-1:0] meas_z [LEGS];
  logic signed [C-1:0] start_x [LEGS];
  logic signed [C-1:0] start_z [LEGS];

  logic acc, leg_ok, active, wr_neu, wr_meas, prime, start, snap;
  logic send_done, slot_end, tick_end;
  logic [1:0] gi;

  assign s_tready  = (state == ST_IDLE);
  assign acc       = s_tvalid & s_tready;
  assign leg_ok    = ({1'b0, in_leg} < (LEG_W+1)'(LEGS));
  assign active    = (gait_mode != GAIT_IDLE);
  assign gi        = gait_mode - 2'd1;
  assign wr_neu    = acc && (s_tuser == REQ_LOAD) && leg_ok;
  assign wr_meas   = acc && (s_tuser == REQ_REPORT) && leg_ok;
  assign prime     = acc && (s_tuser == REQ_TICK) && active && !primed;
  assign start     = acc && (s_tuser == REQ_TICK) && active && primed && !in_moving;
  assign send_done = (state == ST_SEND) && m_tready;
  assign slot_end  = (slot == LW'(LEGS - 1));
  assign tick_end  = send_done && slot_end && (phase[g] == KW'(STEPS - 1));
  assign snap      = prime | tick_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEGS; i++) begin
        neu_x[i]   <= '0;
        neu_y[i]   <= '0;
        neu_z[i]   <= '0;
        meas_x[i]  <= '0;
        meas_z[i]  <= '0;
        start_x[i] <= '0;
        start_z[i] <= '0;
      end
    end else begin
      if (wr_neu) begin
        neu_x[in_leg[LW-1:0]] <= in_x;
        neu_y[in_leg[LW-1:0]] <= in_y;
        neu_z[in_leg[LW-1:0]] <= in_z;
      end
      if (wr_meas) begin
        meas_x[in_leg[LW-1:0]] <= in_x;
        meas_z[in_leg[LW-1:0]] <= in_z;
      end
      if (snap) begin
        for (int i = 0; i < LEGS; i++) begin
          start_x[i] <= meas_x[i];
          start_z[i] <= meas_z[i];
        end
      end
    end
  end

  // phase table
  logic [T_W-1:0] t_tab [STEPS];
  for (genvar kk = 0; kk < STEPS; kk++) begin : g_ttab
    localparam logic [T_W-1:0] TV = T_W'((kk * (1 << Q_FRAC) + STEPS / 2) / STEPS);
    assign t_tab[kk] = TV;
  end

  // stance z offset: stride_z scaled and divided by 6, 1 or 3
  logic [STRIDE_W-1:0] mag;
  logic [STZ_W-2:0]    q1, q3, q6, qsel;
  logic signed [STZ_W-1:0] stz_c;

  assign mag = stride_z[STRIDE_W-1] ? STRIDE_W'(-stride_z) : stride_z;
  assign q1  = {(STZ_W-1)'(mag)} << Q_FRAC;
  assign q3  = (STZ_W-1)'(mag) * (STZ_W-1)'(21845)
             + ((((STZ_W-1)'(mag) + 1'b1) * (STZ_W-1)'(683)) >> 11);
  assign q6  = (STZ_W-1)'(mag) * (STZ_W-1)'(10922)
             + ((((STZ_W-1)'(mag) * 2'd2 + 1'b1) * (STZ_W-1)'(683)) >> 11);

  always_comb begin
    case (gi)
      G_ONE:   qsel = q6;
      G_TRI:   qsel = q1;
      G_TWO:   qsel = q3;
      default: qsel = q1;
    endcase
    stz_c = stride_z[STRIDE_W-1] ? -$signed({1'b0, qsel}) : $signed({1'b0, qsel});
  end

  // current leg operands
  logic [LW-1:0]        lg;
  logic [LW-1:0]        swn;
  logic                 sw;
  logic signed [C-1:0]  nsel, ssel;
  logic signed [MW-1:0] n_m, s_m, st_m, sum_m, dif_m;
  logic signed [W-1:0]  p0, p1, p2, pend, ua, ub, uy;
  logic                 go, udone;

  assign lg = order[g][slot];

  always_comb begin
    case (g)
      G_ONE:   swn = LW'(1);
      G_TRI:   swn = LW'(LEGS / 2);
      G_TWO:   swn = LW'(2);
      default: swn = LW'(1);
    endcase
    sw = (slot < swn);
    case (axis)
      AX_X: begin
        nsel = neu_x[lg];
        ssel = start_x[lg];
        st_m = MW'(stride_x);
      end
      AX_Y: begin
        nsel = neu_y[lg];
        ssel = neu_y[lg];
        st_m = '0;
      end
      default: begin
        nsel = neu_z[lg];
        ssel = start_z[lg];
        st_m = MW'(stride_z);
      end
    endcase
    n_m   = MW'(nsel);
    s_m   = MW'(ssel);
    sum_m = n_m + st_m;
    dif_m = n_m - st_m;
    p0    = $signed({s_m, {Q_FRAC{1'b0}}});
    p1    = (axis == AX_Y) ? '0 : $signed({n_m, {Q_FRAC{1'b0}}});
    p2    = $signed({sum_m, {Q_FRAC{1'b0}}});
    case (axis)
      AX_X:    pend = $signed({dif_m, {Q_FRAC{1'b0}}});
      AX_Y:    pend = $signed({n_m, {Q_FRAC{1'b0}}});
      default: pend = $signed({n_m, {Q_FRAC{1'b0}}}) - W'(stz);
    endcase
    case (op)
      OP_L1: begin
        ua = p0;
        ub = p1;
      end
      OP_L2: begin
        ua = p1;
        ub = p2;
      end
      default: begin
        ua = l1;
        ub = l2;
      end
    endcase
  end

  assign go = (state == ST_ISSUE);

  hgs_lerp #(.W(W)) u_lerp (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .a    (ua),
    .b    (ub),
    .t    (t),
    .done (udone),
    .y    (uy)
  );

  // rounding and saturation of the finished coordinate
  logic signed [W:0]    rw;
  logic signed [MW:0]   rr;
  logic signed [C-1:0]  rsat;

  always_comb begin
    rw = (W+1)'(r) + (r[W-1] ? RND_NEG : RND_POS);
    rr = rw[W:Q_FRAC];
    if (rr > SAT_HI) begin
      rsat = C'(SAT_HI);
    end else if (rr < SAT_LO) begin
      rsat = C'(SAT_LO);
    end else begin
      rsat = C'(rr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      slot   <= '0;
      axis   <= AX_X;
      op     <= OP_L1;
      g      <= G_ONE;
      primed <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        phase[k] <= '0;
      end
      for (int i = 0; i < LEGS; i++) begin
        order[0][i] <= LW'(i);
        order[1][i] <= LW'(tripod_leg(LEGS, i));
        order[2][i] <= LW'(i);
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (prime) begin
            primed <= 1'b1;
          end
          if (start) begin
            g     <= gi;
            t     <= t_tab[phase[gi]];
            stz   <= stz_c;
            slot  <= '0;
            axis  <= AX_X;
            state <= ST_AXIS;
          end
        end
        ST_AXIS: begin
          if (sw) begin
            op <= OP_L1;
          end else begin
            l1 <= p0;
            l2 <= pend;
            op <= OP_FIN;
          end
          state <= ST_ISSUE;
        end
        ST_ISSUE: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (udone) begin
            case (op)
              OP_L1: begin
                l1    <= uy;
                op    <= OP_L2;
                state <= ST_ISSUE;
              end
              OP_L2: begin
                l2    <= uy;
                op    <= OP_FIN;
                state <= ST_ISSUE;
              end
              default: begin
                r     <= uy;
                state <= ST_CONV;
              end
            endcase
          end
        end
        ST_CONV: begin
          case (axis)
            AX_X:    out_x <= rsat;
            AX_Y:    out_y <= rsat;
            default: out_z <= rsat;
          endcase
          if (axis == AX_Z) begin
            out_leg  <= lg;
            out_sw   <= sw;
            out_last <= slot_end;
            state    <= ST_SEND;
          end else begin
            axis  <= axis + 2'd1;
            state <= ST_AXIS;
          end
        end
        ST_SEND: begin
          if (m_tready) begin
            if (slot_end) begin
              state <= ST_IDLE;
              if (tick_end) begin
                phase[g] <= '0;
                for (int i = 0; i < LEGS; i++) begin
                  case (g)
                    G_ONE:   order[0][i] <= order[0][(i + 1) % LEGS];
                    G_TRI:   order[1][i] <= order[1][(i + LEGS / 2) % LEGS];
                    G_TWO:   order[2][i] <= order[2][(i + 2) % LEGS];
                    default: ;
                  endcase
                end
              end else begin
                phase[g] <= phase[g] + 1'b1;
              end
            end else begin
              slot  <= slot + 1'b1;
              axis  <= AX_X;
              state <= ST_AXIS;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid = (state == ST_SEND);
  assign m_tdata  = MDW'({out_z, out_y, out_x, LEG_W'(out_leg)});
  assign m_tuser  = out_sw;
  assign m_tlast  = out_last;

  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input open while a target waits");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
    else $error("no return to idle after final target");

  a_unit_wait: assert property (@(posedge clk) disable iff (rst)
    udone |-> state == ST_WAIT)
    else $error("interpolation result outside wait state");

  a_last_stance: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tuser)
    else $error("final target marked as swing");

endmodule

// ----- hw/rtl/hgs_lerp.sv -----
// Shared three-stage interpolation unit: y = a + round((b - a) * t).
module hgs_lerp #(
  parameter int W = 34
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic signed [W-1:0]       a,
  input  logic signed [W-1:0]       b,
  input  logic [hgs_pkg::T_W-1:0]   t,
  output logic                      done,
  output logic signed [W-1:0]       y
);
  import hgs_pkg::*;

  localparam int PW = W + T_W + 2;
  localparam logic signed [PW-1:0] RND_POS = PW'(1 <<< (Q_FRAC - 1));
  localparam logic signed [PW-1:0] RND_NEG = PW'((1 <<< (Q_FRAC - 1)) - 1);

  logic [2:0]              vld;
  logic signed [W:0]       d;
  logic signed [W-1:0]     a1;
  logic signed [W-1:0]     a2;
  logic signed [PW-1:0]    p;
  logic signed [PW-1:0]    pr;

  assign pr   = p + (p[PW-1] ? RND_NEG : RND_POS);
  assign done = vld[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], go};
    end
  end

  always_ff @(posedge clk) begin
    d  <= (W+1)'(b) - (W+1)'(a);
    a1 <= a;
    p  <= d * $signed({1'b0, t});
    a2 <= a1;
    y  <= a2 + W'(pr >>> Q_FRAC);
  end

endmodule

// ----- tb/sv/tb_hexapod_gait_sequencer.sv -----
// Self-checking testbench for hexapod_gait_sequencer: random requests with a built-in predictor.
`timescale 1ns / 1ps

module tb_hexapod_gait_sequencer;
  import hgs_pkg::*;

  localparam int NLEGS = 6;
  localparam int NSTEPS = 10;
  localparam int SETTLE = 300;
  localparam logic [REQ_W-1:0] REQ_BAD = 2'd3;
  localparam logic [MODE_W-1:0] GAIT_WAVE = 2'd1;
  localparam logic [MODE_W-1:0] GAIT_TRIPOD = 2'd2;
  localparam logic [MODE_W-1:0] GAIT_RIPPLE = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic [2:0] leg;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic moving;
  } leg_req_t;

  typedef struct packed {
    logic [2:0] leg;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic sw;
    logic lst;
  } foot_target_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [55:0] s_tdata = '0;
  logic [REQ_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic m_tuser;
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [STRIDE_W-1:0] cfg_data = '0;

  always #6 clk = ~clk;

  hexapod_gait_sequencer u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // gait state mirror
  logic [MODE_W-1:0] gm_mode;
  logic signed [STRIDE_W-1:0] gm_sx, gm_sz;
  longint nx[NLEGS], ny[NLEGS], nz[NLEGS];
  longint mx[NLEGS], my[NLEGS], mz[NLEGS];
  longint st_x[NLEGS], st_z[NLEGS];
  int order[3][NLEGS];
  int phase[3];
  bit primed;

  leg_req_t pending[$];
  foot_target_t targets_due[$];
  leg_req_t cur_req;
  bit taken = 0;
  int gap_left = 0, stall_left = 0;
  bit no_idle = 0;
  int errors = 0, n_reqs = 0, n_targets = 0, n_ticks = 0;

  function automatic longint rs16(longint v);
    if (v >= 0) return (v + 32768) >>> 16;
    return -((-v + 32768) >>> 16);
  endfunction

  function automatic longint rdiv(longint v, longint d);
    if (v >= 0) return (v + d / 2) / d;
    return -((-v + d / 2) / d);
  endfunction

  function automatic longint lerp_q(longint a, longint b, longint t);
    return a + rs16((b - a) * t);
  endfunction

  function automatic longint bez_q(longint p0, longint p1, longint p2, longint t);
    return lerp_q(lerp_q(p0, p1, t), lerp_q(p1, p2, t), t);
  endfunction

  function automatic logic [15:0] to_mm(longint q);
    longint v;
    v = rs16(q);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic gait_reset();
    int tri_ord[NLEGS];
    tri_ord = '{0, 3, 4, 1, 2, 5};
    gm_mode = GAIT_IDLE;
    gm_sx = '0;
    gm_sz = STRIDE_Z_RST;
    primed = 0;
    for (int i = 0; i < NLEGS; i++) begin
      nx[i] = 0; ny[i] = 0; nz[i] = 0;
      mx[i] = 0; my[i] = 0; mz[i] = 0;
      st_x[i] = 0; st_z[i] = 0;
      for (int g = 0; g < 3; g++) order[g][i] = (g == 1) ? tri_ord[i] : i;
    end
    for (int g = 0; g < 3; g++) phase[g] = 0;
  endtask

  task automatic snap_starts();
    for (int i = 0; i < NLEGS; i++) begin
      st_x[i] = mx[i];
      st_z[i] = mz[i];
    end
  endtask

  task automatic predict_targets(leg_req_t r);
    int g, sn, k, lg;
    int tmp[NLEGS];
    longint t, sxq, szq, stz, rx, ry, rz;
    foot_target_t ft;
    if (r.req == REQ_LOAD || r.req == REQ_REPORT) begin
      if (r.leg >= NLEGS) return;
      if (r.req == REQ_LOAD) begin
        nx[r.leg] = longint'(r.x) * 65536;
        ny[r.leg] = longint'(r.y) * 65536;
        nz[r.leg] = longint'(r.z) * 65536;
      end else begin
        mx[r.leg] = longint'(r.x) * 65536;
        my[r.leg] = longint'(r.y) * 65536;
        mz[r.leg] = longint'(r.z) * 65536;
      end
      return;
    end
    if (r.req != REQ_TICK || gm_mode == GAIT_IDLE) return;
    if (!primed) begin
      snap_starts();
      primed = 1;
      return;
    end
    if (r.moving) return;
    n_ticks++;
    g = gm_mode - 1;
    sn = (gm_mode == GAIT_WAVE) ? 1 : (gm_mode == GAIT_TRIPOD) ? NLEGS / 2 : 2;
    k = (phase[g] >= NSTEPS) ? 0 : phase[g];
    t = (longint'(k) * 65536 + NSTEPS / 2) / NSTEPS;
    sxq = longint'(gm_sx) * 65536;
    szq = longint'(gm_sz) * 65536;
    stz = rdiv(szq, (gm_mode == GAIT_WAVE) ? 6 : (gm_mode == GAIT_TRIPOD) ? 1 : 3);
    for (int i = 0; i < NLEGS; i++) begin
      lg = order[g][i] % NLEGS;
      if (i < sn) begin
        rx = bez_q(st_x[lg], nx[lg], nx[lg] + sxq, t);
        ry = bez_q(ny[lg], 0, ny[lg], t);
        rz = bez_q(st_z[lg], nz[lg], nz[lg] + szq, t);
      end else begin
        rx = lerp_q(st_x[lg], nx[lg] - sxq, t);
        ry = ny[lg];
        rz = lerp_q(st_z[lg], nz[lg] - stz, t);
      end
      ft.leg = lg[2:0];
      ft.x = to_mm(rx);
      ft.y = to_mm(ry);
      ft.z = to_mm(rz);
      ft.sw = (i < sn);
      ft.lst = (i == NLEGS - 1);
      targets_due.push_back(ft);
    end
    if (k + 1 >= NSTEPS) begin
      phase[g] = 0;
      for (int i = 0; i < NLEGS; i++) tmp[i] = order[g][(i + sn) % NLEGS];
      for (int i = 0; i < NLEGS; i++) order[g][i] = tmp[i];
      snap_starts();
    end else begin
      phase[g] = k + 1;
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || taken) begin
      taken = 0;
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending.size() > 0) begin
        cur_req = pending.pop_front();
        s_tdata <= {4'b0, cur_req.moving, cur_req.z, cur_req.y, cur_req.x, cur_req.leg};
        s_tuser <= cur_req.req;
        s_tvalid <= 1'b1;
        gap_left = no_idle ? 0 : $urandom_range(0, 10);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    foot_target_t got, want;
    if (!rst && s_tvalid && s_tready && !taken) begin
      taken = 1;
      n_reqs++;
      predict_targets(cur_req);
    end
    if (!rst && m_tvalid && m_tready) begin
      n_targets++;
      stall_left = no_idle ? 0 : $urandom_range(0, 10);
      got = {m_tdata[2:0], m_tdata[18:3], m_tdata[34:19], m_tdata[50:35], m_tuser, m_tlast};
      if (targets_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected target %h", got);
      end else begin
        want = targets_due.pop_front();
        if (got != want) begin
          errors++;
          if (errors <= 10)
            $display("target mismatch: leg %0d/%0d x %0d/%0d y %0d/%0d z %0d/%0d sw %b/%b last %b/%b",
                     want.leg, got.leg, $signed(want.x), $signed(got.x), $signed(want.y),
                     $signed(got.y), $signed(want.z), $signed(got.z), want.sw, got.sw,
                     want.lst, got.lst);
        end
      end
    end
  end

  task automatic wait_quiet();
    do @(posedge clk);
    while (pending.size() > 0 || s_tvalid || targets_due.size() > 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [STRIDE_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_MODE) gm_mode = val[MODE_W-1:0];
    else if (idx == CFG_STRIDE_X) gm_sx = val;
    else if (idx == CFG_STRIDE_Z) gm_sz = val;
  endtask

  task automatic set_gait(logic [MODE_W-1:0] md, logic [STRIDE_W-1:0] sx,
                          logic [STRIDE_W-1:0] sz);
    wait_quiet();
    write_reg(CFG_MODE, STRIDE_W'(md));
    write_reg(CFG_STRIDE_X, sx);
    write_reg(CFG_STRIDE_Z, sz);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_req(logic [REQ_W-1:0] rq, int lg, int x, int y, int z, bit mv);
    leg_req_t r;
    r.req = rq;
    r.leg = lg[2:0];
    r.x = x[15:0];
    r.y = y[15:0];
    r.z = z[15:0];
    r.moving = mv;
    pending.push_back(r);
  endtask

  function automatic int rand_coord();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 65535) - 32768;
    return $urandom_range(0, 800) - 400;
  endfunction

  task automatic add_random_req();
    int c;
    c = $urandom_range(0, 99);
    if (c < 12)
      add_req(REQ_LOAD, $urandom_range(0, 5), rand_coord(), rand_coord(), rand_coord(),
              $urandom_range(0, 1) != 0);
    else if (c < 35)
      add_req(REQ_REPORT, $urandom_range(0, 5), rand_coord(), rand_coord(), rand_coord(),
              $urandom_range(0, 1) != 0);
    else if (c < 40)
      add_req(($urandom_range(0, 1) != 0) ? REQ_BAD : REQ_LOAD, $urandom_range(6, 7),
              rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 1) != 0);
    else
      add_req(REQ_TICK, $urandom_range(0, 7), rand_coord(), rand_coord(), rand_coord(),
              $urandom_range(0, 7) == 0);
  endtask

  initial begin
    logic [MODE_W-1:0] pm[8];
    int psx[8], psz[8];
    gait_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // idle gait: stores, extremes, ignored requests; then wave gait at full stride
    add_req(REQ_LOAD, 0, 32767, -32768, 32767, 0);
    add_req(REQ_LOAD, 1, -32768, 32767, -32768, 1);
    add_req(REQ_LOAD, 2, 100, -50, 200, 0);
    add_req(REQ_LOAD, 3, -120, 0, 180, 0);
    add_req(REQ_LOAD, 4, 90, 40, -160, 0);
    add_req(REQ_LOAD, 5, -80, -40, 150, 0);
    add_req(REQ_REPORT, 0, -32768, 32767, -32768, 0);
    add_req(REQ_REPORT, 1, 32767, -32768, 32767, 0);
    add_req(REQ_REPORT, 3, 10, 20, 30, 0);
    add_req(REQ_LOAD, 6, 1, 2, 3, 0);
    add_req(REQ_REPORT, 7, 4, 5, 6, 0);
    add_req(REQ_BAD, 2, 7, 8, 9, 1);
    add_req(REQ_TICK, 0, 0, 0, 0, 0);
    set_gait(GAIT_WAVE, 10'sd511, 10'sd511);
    add_req(REQ_TICK, 0, 0, 0, 0, 0);
    add_req(REQ_TICK, 0, 0, 0, 0, 1);
    for (int i = 0; i < 8; i++) add_req(REQ_TICK, 0, 0, 0, 0, 0);

    pm = '{GAIT_TRIPOD, GAIT_RIPPLE, GAIT_WAVE, GAIT_IDLE, GAIT_TRIPOD, GAIT_RIPPLE,
           GAIT_WAVE, GAIT_TRIPOD};
    psx = '{-512, 511, 37, 0, 0, -200, 120, 511};
    psz = '{511, -512, -90, 5, 0, 77, -300, -512};
    for (int p = 0; p < 8; p++) begin
      if (p >= 4 && p < 7) begin
        psx[p] = $urandom_range(0, 1023) - 512;
        psz[p] = $urandom_range(0, 1023) - 512;
      end
      set_gait(pm[p], psx[p][STRIDE_W-1:0], psz[p][STRIDE_W-1:0]);
      no_idle = (p % 3 == 2);
      for (int i = 0; i < 56; i++) add_random_req();
    end

    wait_quiet();
    $display("%0d requests accepted, %0d gait ticks, %0d foot targets checked",
             n_reqs, n_ticks, n_targets);
    $display("covered wave, tripod and ripple gaits, idle mode and stride extremes");
    if (errors == 0 && targets_due.size() == 0) begin
      $display("hexapod_gait_sequencer test passed");
    end else begin
      $display("%0d mismatches, %0d targets outstanding", errors, targets_due.size());
      $display("hexapod_gait_sequencer test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("hexapod_gait_sequencer test failed");
    $finish;
  end

endmodule
